@@ rtl/cpe_pkg.sv @@
// ---------------------------------------------------------------------------
// Critical path event times: shared package
// Types, codes and constants used by the front end, the back end and the top.
// ---------------------------------------------------------------------------
package cpe_pkg;

  // Default sizes.
  localparam int MAX_NODES_DEF   = 32;
  localparam int WEIGHT_BITS_DEF = 16;

  // Fixed field widths.
  localparam int TIME_W   = 22;
  localparam int MODE_W   = 2;
  localparam int NODE_W   = 5;
  localparam int EWGT_W   = 16;
  localparam int NCNT_W   = 6;
  localparam int MASK_W   = 4;
  localparam int STATUS_W = 2;
  localparam int CFG_DW   = 6;
  localparam int CFG_IW   = 1;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Input mode codes.
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BACKWARD = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_NODE_COUNT  = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_REPORT_MASK = 1'd1;

  // Report mask bits.
  localparam int RM_EARLY   = 0;
  localparam int RM_LATE    = 1;
  localparam int RM_RESERVE = 2;
  localparam int RM_CRIT    = 3;

  // Command queued from the front end to the back end.
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_RUN,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e  op;
    logic backward;
  } cmd_t;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FWD_RD,
    S_FWD_ACC,
    S_BWD_INIT,
    S_BWD_RD,
    S_BWD_ACC,
    S_RES,
    S_OUT_RD,
    S_OUT_ACC,
    S_EMIT,
    S_ERR
  } state_e;

endpackage

@@ rtl/cpe_front.sv @@
// ---------------------------------------------------------------------------
// Critical path event times: front end
// Accepts words, classifies them into commands and queues them (depth two).
// ---------------------------------------------------------------------------
module cpe_front #(
  parameter int MAX_NODES   = cpe_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = cpe_pkg::WEIGHT_BITS_DEF,
  localparam int AW = $clog2(MAX_NODES * MAX_NODES)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         hold_i,
  output logic                         busy,
  input  logic [cpe_pkg::MODE_W-1:0]   mode_i,
  input  logic [cpe_pkg::NODE_W-1:0]   from_node_i,
  input  logic [cpe_pkg::NODE_W-1:0]   to_node_i,
  input  logic [cpe_pkg::EWGT_W-1:0]   edge_weight_i,
  output logic                         cmd_valid_o,
  output cpe_pkg::cmd_t                cmd_o,
  output logic [AW-1:0]                cmd_addr_o,
  output logic [WEIGHT_BITS-1:0]       cmd_weight_o,
  input  logic                         cmd_pop_i
);

  cpe_pkg::cmd_t        ent_cmd_q [2];
  logic [AW-1:0]        ent_addr_q [2];
  logic [WEIGHT_BITS-1:0] ent_wgt_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           cnt_q;
  logic                 accept, push, in_range;
  cpe_pkg::cmd_t        new_cmd;

  assign busy     = (cnt_q == 2'd2) || hold_i;
  assign accept   = start && !busy;
  assign in_range = (int'(from_node_i) < MAX_NODES) && (int'(to_node_i) < MAX_NODES);

  // Classify the incoming word; unused modes and out-of-range loads are dropped.
  always_comb begin
    new_cmd.op       = cpe_pkg::OP_LOAD;
    new_cmd.backward = from_node_i > to_node_i;
    push             = 1'b0;
    case (mode_i)
      cpe_pkg::MODE_LOAD: begin
        new_cmd.op = cpe_pkg::OP_LOAD;
        push       = accept && in_range;
      end
      cpe_pkg::MODE_RUN: begin
        new_cmd.op = cpe_pkg::OP_RUN;
        push       = accept;
      end
      cpe_pkg::MODE_CLEAR: begin
        new_cmd.op = cpe_pkg::OP_CLEAR;
        push       = accept;
      end
      default: push = 1'b0;
    endcase
  end

  // Queue payload.
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_cmd_q[wr_ptr_q]  <= new_cmd;
      ent_addr_q[wr_ptr_q] <= AW'(AW'(from_node_i) * AW'(MAX_NODES) + AW'(to_node_i));
      ent_wgt_q[wr_ptr_q]  <= WEIGHT_BITS'(edge_weight_i);
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

  assign cmd_valid_o  = cnt_q != 2'd0;
  assign cmd_o        = ent_cmd_q[rd_ptr_q];
  assign cmd_addr_o   = ent_addr_q[rd_ptr_q];
  assign cmd_weight_o = ent_wgt_q[rd_ptr_q];

endmodule

@@ rtl/cpe_back.sv @@
// ---------------------------------------------------------------------------
// Critical path event times: back end
// Owns the edge weight memory and sequences loads, clears and runs.
// ---------------------------------------------------------------------------
module cpe_back #(
  parameter int MAX_NODES   = cpe_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = cpe_pkg::WEIGHT_BITS_DEF,
  localparam int AW = $clog2(MAX_NODES * MAX_NODES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  cpe_pkg::cmd_t                 cmd_i,
  input  logic [AW-1:0]                 cmd_addr_i,
  input  logic [WEIGHT_BITS-1:0]        cmd_weight_i,
  output logic                          cmd_pop_o,
  output logic                          init_o,
  input  logic [cpe_pkg::NCNT_W-1:0]    node_count_i,
  input  logic [cpe_pkg::MASK_W-1:0]    report_mask_i,
  output logic                          result_valid_o,
  output logic [cpe_pkg::STATUS_W-1:0]  status_o,
  output logic [cpe_pkg::NODE_W-1:0]    node_index_o,
  output logic [cpe_pkg::TIME_W-1:0]    early_time_o,
  output logic [cpe_pkg::TIME_W-1:0]    late_time_o,
  output logic [cpe_pkg::TIME_W-1:0]    reserve_time_o,
  output logic                          crit_pred_valid_o,
  output logic [cpe_pkg::NODE_W-1:0]    crit_pred_o,
  output logic                          last_o
);

  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int IW    = $clog2(MAX_NODES);
  localparam int NW    = $clog2(MAX_NODES + 1);
  localparam int TW    = cpe_pkg::TIME_W;
  localparam int SW    = ((WEIGHT_BITS > TW) ? WEIGHT_BITS : TW) + 1;
  localparam int EW    = WEIGHT_BITS + 1;

  cpe_pkg::state_e state_q, state_d;

  // Edge memory: valid bit over weight, one write port and one read port, registered read.
  logic [EW-1:0] mem_q [DEPTH];
  logic [EW-1:0] rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata;

  logic [TW-1:0] early_q [MAX_NODES];
  logic [TW-1:0] late_q [MAX_NODES];
  logic          resz_q [MAX_NODES];

  logic [AW-1:0] clr_q, clr_d;
  logic          init_q, init_d;
  logic          bwd_q, bwd_d;
  logic [NW-1:0] i_q, i_d, k_q, k_d;
  logic [TW-1:0] best_q, best_d;
  logic          pv_q, pv_d;
  logic [IW-1:0] p_q, p_d;

  logic                        rv_q, rv_d, last_q, last_d, opv_q, opv_d;
  logic [cpe_pkg::STATUS_W-1:0] st_q, st_d;
  logic [cpe_pkg::NODE_W-1:0]  idx_q, idx_d, op_q, op_d;
  logic [TW-1:0]               oe_q, oe_d, ol_q, ol_d, or_q, or_d;

  logic [NW-1:0] n;
  logic [IW-1:0] row, col, eidx, lidx;
  logic [TW-1:0] early_rd, late_rd, fwd_t, bwd_t, res_v;
  logic [SW-1:0] sum;
  logic          ent_on;
  logic [WEIGHT_BITS-1:0] ent_w;
  logic          e_we, l_we, z_we;
  logic [IW-1:0] e_wa, l_wa, z_wa;
  logic [TW-1:0] e_wd, l_wd;
  logic          z_wd;
  logic          k_eq_i, clr_end;

  // Node count clamped to the array size.
  always_comb begin
    if (int'(node_count_i) > MAX_NODES) n = NW'(MAX_NODES);
    else n = NW'(node_count_i);
  end

  assign ent_on   = rd_q[EW-1];
  assign ent_w    = rd_q[WEIGHT_BITS-1:0];
  assign k_eq_i   = k_q == i_q;
  assign clr_end  = int'(clr_q) == DEPTH - 1;
  assign early_rd = early_q[eidx];
  assign late_rd  = late_q[lidx];

  // Path arithmetic: saturating forward sum, clamped backward difference and reserve.
  always_comb begin
    sum = SW'(ent_w) + SW'(early_rd);
    if (sum > SW'(cpe_pkg::TIME_MAX)) fwd_t = cpe_pkg::TIME_MAX;
    else fwd_t = sum[TW-1:0];
    if (SW'(late_rd) >= SW'(ent_w)) bwd_t = TW'(SW'(late_rd) - SW'(ent_w));
    else bwd_t = '0;
    if (late_rd >= early_rd) res_v = late_rd - early_rd;
    else res_v = '0;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cpe_pkg::S_CLEAR: if (clr_end) state_d = cpe_pkg::S_IDLE;
      cpe_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            cpe_pkg::OP_CLEAR: state_d = cpe_pkg::S_CLEAR;
            cpe_pkg::OP_RUN: begin
              if (n == '0 || bwd_q) state_d = cpe_pkg::S_ERR;
              else state_d = cpe_pkg::S_FWD_RD;
            end
            default: state_d = cpe_pkg::S_IDLE;
          endcase
        end
      end
      cpe_pkg::S_FWD_RD: begin
        if (!k_eq_i) state_d = cpe_pkg::S_FWD_ACC;
        else if (i_q == n - 1'b1) state_d = cpe_pkg::S_BWD_INIT;
      end
      cpe_pkg::S_FWD_ACC: state_d = cpe_pkg::S_FWD_RD;
      cpe_pkg::S_BWD_INIT: begin
        if (n == NW'(1)) state_d = cpe_pkg::S_RES;
        else state_d = cpe_pkg::S_BWD_RD;
      end
      cpe_pkg::S_BWD_RD: begin
        if (!k_eq_i) state_d = cpe_pkg::S_BWD_ACC;
        else if (i_q == '0) state_d = cpe_pkg::S_RES;
      end
      cpe_pkg::S_BWD_ACC: state_d = cpe_pkg::S_BWD_RD;
      cpe_pkg::S_RES: if (i_q == n - 1'b1) state_d = cpe_pkg::S_OUT_RD;
      cpe_pkg::S_OUT_RD: begin
        if (resz_q[i_q[IW-1:0]] && !k_eq_i) state_d = cpe_pkg::S_OUT_ACC;
        else state_d = cpe_pkg::S_EMIT;
      end
      cpe_pkg::S_OUT_ACC: state_d = cpe_pkg::S_OUT_RD;
      cpe_pkg::S_EMIT: begin
        if (i_q == n - 1'b1) state_d = cpe_pkg::S_IDLE;
        else state_d = cpe_pkg::S_OUT_RD;
      end
      cpe_pkg::S_ERR: state_d = cpe_pkg::S_IDLE;
      default: state_d = cpe_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory control and result words.
  always_comb begin
    clr_d = clr_q; init_d = init_q; bwd_d = bwd_q;
    i_d = i_q; k_d = k_q; best_d = best_q; pv_d = pv_q; p_d = p_q;
    rv_d = 1'b0; st_d = st_q; idx_d = idx_q; oe_d = oe_q; ol_d = ol_q;
    or_d = or_q; opv_d = opv_q; op_d = op_q; last_d = last_q;
    cmd_pop_o = 1'b0;
    mem_we = 1'b0; mem_waddr = cmd_addr_i; mem_wdata = {1'b1, cmd_weight_i};
    row = k_q[IW-1:0]; col = i_q[IW-1:0];
    eidx = i_q[IW-1:0]; lidx = i_q[IW-1:0];
    e_we = 1'b0; e_wa = i_q[IW-1:0]; e_wd = best_q;
    l_we = 1'b0; l_wa = i_q[IW-1:0]; l_wd = best_q;
    z_we = 1'b0; z_wa = i_q[IW-1:0]; z_wd = late_rd <= early_rd;
    case (state_q)
      cpe_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        bwd_d     = 1'b0;
        clr_d     = clr_end ? '0 : clr_q + 1'b1;
        if (clr_end) init_d = 1'b0;
      end
      cpe_pkg::S_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        i_d = '0; k_d = '0; best_d = '0;
        if (cmd_valid_i && cmd_i.op == cpe_pkg::OP_LOAD) begin
          mem_we = 1'b1;
          if (cmd_i.backward) bwd_d = 1'b1;
        end
      end
      cpe_pkg::S_FWD_RD: begin
        if (k_eq_i) begin
          e_we   = 1'b1;
          i_d    = i_q + 1'b1;
          k_d    = '0;
          best_d = '0;
        end
      end
      cpe_pkg::S_FWD_ACC: begin
        eidx = k_q[IW-1:0];
        if (ent_on && fwd_t > best_q) best_d = fwd_t;
        k_d = k_q + 1'b1;
      end
      cpe_pkg::S_BWD_INIT: begin
        eidx   = IW'(n - 1'b1);
        l_we   = 1'b1;
        l_wa   = IW'(n - 1'b1);
        l_wd   = early_rd;
        i_d    = (n == NW'(1)) ? '0 : n - NW'(2);
        k_d    = n - 1'b1;
        best_d = cpe_pkg::TIME_MAX;
      end
      cpe_pkg::S_BWD_RD: begin
        row = i_q[IW-1:0];
        col = k_q[IW-1:0];
        if (k_eq_i) begin
          l_we   = 1'b1;
          i_d    = (i_q == '0) ? '0 : i_q - 1'b1;
          k_d    = n - 1'b1;
          best_d = cpe_pkg::TIME_MAX;
        end
      end
      cpe_pkg::S_BWD_ACC: begin
        lidx = k_q[IW-1:0];
        if (ent_on && bwd_t < best_q) best_d = bwd_t;
        k_d = k_q - 1'b1;
      end
      cpe_pkg::S_RES: begin
        z_we = 1'b1;
        i_d  = (i_q == n - 1'b1) ? '0 : i_q + 1'b1;
        k_d  = '0;
        pv_d = 1'b0;
        p_d  = '0;
      end
      cpe_pkg::S_OUT_ACC: begin
        if (ent_on && resz_q[k_q[IW-1:0]]) begin
          pv_d = 1'b1;
          p_d  = k_q[IW-1:0];
        end
        k_d = k_q + 1'b1;
      end
      cpe_pkg::S_EMIT: begin
        rv_d   = 1'b1;
        st_d   = cpe_pkg::ST_OK;
        idx_d  = cpe_pkg::NODE_W'(i_q);
        oe_d   = report_mask_i[cpe_pkg::RM_EARLY] ? early_rd : '0;
        ol_d   = report_mask_i[cpe_pkg::RM_LATE] ? late_rd : '0;
        or_d   = report_mask_i[cpe_pkg::RM_RESERVE] ? res_v : '0;
        opv_d  = report_mask_i[cpe_pkg::RM_CRIT] && pv_q;
        op_d   = (report_mask_i[cpe_pkg::RM_CRIT] && pv_q) ? cpe_pkg::NODE_W'(p_q) : '0;
        last_d = i_q == n - 1'b1;
        i_d    = i_q + 1'b1;
        k_d    = '0;
        pv_d   = 1'b0;
        p_d    = '0;
      end
      cpe_pkg::S_ERR: begin
        rv_d   = 1'b1;
        st_d   = (n == '0) ? cpe_pkg::ST_EMPTY : cpe_pkg::ST_BACKWARD;
        idx_d  = '0;
        oe_d   = '0;
        ol_d   = '0;
        or_d   = '0;
        opv_d  = 1'b0;
        op_d   = '0;
        last_d = 1'b1;
      end
      default: ;
    endcase
    mem_raddr = AW'(AW'(row) * AW'(MAX_NODES) + AW'(col));
  end

  // Edge memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_q <= mem_q[mem_raddr];
  end

  // Per-node time and zero-reserve stores.
  always_ff @(posedge clk_i) begin
    if (e_we) early_q[e_wa] <= e_wd;
    if (l_we) late_q[l_wa] <= l_wd;
    if (z_we) resz_q[z_wa] <= z_wd;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpe_pkg::S_CLEAR;
      clr_q   <= '0;
      init_q  <= 1'b1;
      bwd_q   <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      init_q  <= init_d;
      bwd_q   <= bwd_d;
      rv_q    <= rv_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    k_q    <= k_d;
    best_q <= best_d;
    pv_q   <= pv_d;
    p_q    <= p_d;
    st_q   <= st_d;
    idx_q  <= idx_d;
    oe_q   <= oe_d;
    ol_q   <= ol_d;
    or_q   <= or_d;
    opv_q  <= opv_d;
    op_q   <= op_d;
    last_q <= last_d;
  end

  assign init_o            = init_q;
  assign result_valid_o    = rv_q;
  assign status_o          = st_q;
  assign node_index_o      = idx_q;
  assign early_time_o      = oe_q;
  assign late_time_o       = ol_q;
  assign reserve_time_o    = or_q;
  assign crit_pred_valid_o = opv_q;
  assign crit_pred_o       = op_q;
  assign last_o            = last_q;

endmodule

@@ rtl/critical_path_event_times.sv @@
// ---------------------------------------------------------------------------
// Critical path event times: top level
// Flow: an edge load is queued in the front end and written to the edge memory
// when the back end takes it from the queue while idle. A mode-3 word is
// dropped on entry. A clear zeroes all MAX_NODES*MAX_NODES edge entries.
// A run does the forward pass, the backward pass, the reserves and then the
// output scan. Results are never given back to back, and the receiver cannot
// stall them. Reset runs a clearing pass over the edge memory with busy high.
// ---------------------------------------------------------------------------
module critical_path_event_times #(
  parameter int MAX_NODES   = cpe_pkg::MAX_NODES_DEF,
  parameter int WEIGHT_BITS = cpe_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cpe_pkg::CFG_IW-1:0]    cfg_idx_i,
  input  logic [cpe_pkg::CFG_DW-1:0]    cfg_data_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [cpe_pkg::MODE_W-1:0]    mode_i,
  input  logic [cpe_pkg::NODE_W-1:0]    from_node_i,
  input  logic [cpe_pkg::NODE_W-1:0]    to_node_i,
  input  logic [cpe_pkg::EWGT_W-1:0]    edge_weight_i,
  output logic                          result_valid_o,
  output logic [cpe_pkg::STATUS_W-1:0]  status_o,
  output logic [cpe_pkg::NODE_W-1:0]    node_index_o,
  output logic [cpe_pkg::TIME_W-1:0]    early_time_o,
  output logic [cpe_pkg::TIME_W-1:0]    late_time_o,
  output logic [cpe_pkg::TIME_W-1:0]    reserve_time_o,
  output logic                          crit_pred_valid_o,
  output logic [cpe_pkg::NODE_W-1:0]    crit_pred_o,
  output logic                          last_o
);

  localparam int AW = $clog2(MAX_NODES * MAX_NODES);

  logic [cpe_pkg::NCNT_W-1:0] node_count_q;
  logic [cpe_pkg::MASK_W-1:0] report_mask_q;
  logic                       cmd_valid, cmd_pop, init;
  cpe_pkg::cmd_t              cmd;
  logic [AW-1:0]              cmd_addr;
  logic [WEIGHT_BITS-1:0]     cmd_weight;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= '0;
      report_mask_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpe_pkg::CFG_NODE_COUNT:  node_count_q  <= cfg_data_i[cpe_pkg::NCNT_W-1:0];
        cpe_pkg::CFG_REPORT_MASK: report_mask_q <= cfg_data_i[cpe_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  cpe_front #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .hold_i        (init),
    .busy          (busy),
    .mode_i        (mode_i),
    .from_node_i   (from_node_i),
    .to_node_i     (to_node_i),
    .edge_weight_i (edge_weight_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_addr_o    (cmd_addr),
    .cmd_weight_o  (cmd_weight),
    .cmd_pop_i     (cmd_pop)
  );

  cpe_back #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (cmd),
    .cmd_addr_i        (cmd_addr),
    .cmd_weight_i      (cmd_weight),
    .cmd_pop_o         (cmd_pop),
    .init_o            (init),
    .node_count_i      (node_count_q),
    .report_mask_i     (report_mask_q),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .node_index_o      (node_index_o),
    .early_time_o      (early_time_o),
    .late_time_o       (late_time_o),
    .reserve_time_o    (reserve_time_o),
    .crit_pred_valid_o (crit_pred_valid_o),
    .crit_pred_o       (crit_pred_o),
    .last_o            (last_o)
  );

  // An error result is always the single, final word of its run.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != cpe_pkg::ST_OK |-> last_o && node_index_o == '0)
    else $error("error result not single");

  // A critical predecessor always precedes its node.
  a_pred_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && crit_pred_valid_o |-> crit_pred_o < node_index_o)
    else $error("critical predecessor out of order");

  // A node with reserve has no critical predecessor.
  a_pred_zero_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && reserve_time_o != '0 |-> !crit_pred_valid_o)
    else $error("critical predecessor on node with reserve");

  // No word is taken while the clearing pass after reset runs.
  a_init_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init |-> busy)
    else $error("accepting during reset clear");

endmodule
